>>> src/balance_cascade_pid_macros.svh
// Assertion helpers for the balance controller.
`ifndef BALANCE_CASCADE_PID_MACROS_SVH
`define BALANCE_CASCADE_PID_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define BCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> src/bcp_pkg.sv
package bcp_pkg;

  // loop limits
  localparam int SPEED_TARGET_MAX = 20;
  localparam int TURN_TARGET_MAX  = 150;
  localparam int INTEGRAL_MAX     = 20000;

  localparam int RANGE_NEAR = 25;
  localparam int TURN_STEP  = 30;

  // field widths
  localparam int ENC_W   = 16;
  localparam int ANGLE_W = 17;
  localparam int RATE_W  = 16;
  localparam int RANGE_W = 10;
  localparam int MOTOR_W = 16;

  // register widths
  localparam int UKP_W   = 26;
  localparam int UKD_W   = 20;
  localparam int SKP_W   = 17;
  localparam int TKP_W   = 21;
  localparam int TKD_W   = 18;
  localparam int BOFS_W  = 13;
  localparam int FCOEF_W = 17;
  localparam int MLIM_W  = 15;

  // loop state widths
  localparam int ST_W    = 6;
  localparam int TT_W    = 9;
  localparam int INTEG_W = 16;
  localparam int FE_W    = 18;
  localparam int ERR_W   = 18;

  // shared multiplier: unsigned A times signed B
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam int UP_W  = 30;
  localparam int TN_W  = 20;
  localparam int MIX_W = 31;

  localparam logic [FCOEF_W-1:0] Q16_ONE = FCOEF_W'(65536);
  localparam int Q16_BIAS = 65535;
  localparam int Q24_BIAS = 16777215;

  // integral gain divisor, and exact reciprocal for magnitudes below 2^30
  localparam int SPEED_I_DIV = 200;
  localparam logic [MUL_A_W-1:0] INV200 = MUL_A_W'(42949673);
  localparam int INV200_SHIFT = 33;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_KP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_KD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAL_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_LIM  = 3'd7;

  localparam logic [UKP_W-1:0]          RST_UPRIGHT_KP = UKP_W'(18350080);
  localparam logic [UKD_W-1:0]          RST_UPRIGHT_KD = UKD_W'(117965);
  localparam logic [SKP_W-1:0]          RST_SPEED_KP   = SKP_W'(26214);
  localparam logic [TKP_W-1:0]          RST_TURN_KP    = TKP_W'(655360);
  localparam logic [TKD_W-1:0]          RST_TURN_KD    = TKD_W'(39322);
  localparam logic signed [BOFS_W-1:0]  RST_BAL_OFFSET = BOFS_W'(256);
  localparam logic [FCOEF_W-1:0]        RST_FILTER     = FCOEF_W'(45875);
  localparam logic [MLIM_W-1:0]         RST_MOTOR_LIM  = MLIM_W'(7200);

  // sequencer steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_FE_A      = 5'd0;
  localparam logic [STEP_W-1:0] S_FE_B      = 5'd1;
  localparam logic [STEP_W-1:0] S_FE_SUM    = 5'd2;
  localparam logic [STEP_W-1:0] S_FE_TRUNC  = 5'd3;
  localparam logic [STEP_W-1:0] S_INTEG     = 5'd4;
  localparam logic [STEP_W-1:0] S_VSUM      = 5'd5;
  localparam logic [STEP_W-1:0] S_VMUL      = 5'd6;
  localparam logic [STEP_W-1:0] S_VQ16      = 5'd7;
  localparam logic [STEP_W-1:0] S_VABS      = 5'd8;
  localparam logic [STEP_W-1:0] S_VDIV      = 5'd9;
  localparam logic [STEP_W-1:0] S_VSIGN     = 5'd10;
  localparam logic [STEP_W-1:0] S_DANG      = 5'd11;
  localparam logic [STEP_W-1:0] S_UP_P      = 5'd12;
  localparam logic [STEP_W-1:0] S_UP_D      = 5'd13;
  localparam logic [STEP_W-1:0] S_UP_SUM    = 5'd14;
  localparam logic [STEP_W-1:0] S_UP_TRUNC  = 5'd15;
  localparam logic [STEP_W-1:0] S_TN_D      = 5'd16;
  localparam logic [STEP_W-1:0] S_TN_SUM    = 5'd17;
  localparam logic [STEP_W-1:0] S_TN_TRUNC  = 5'd18;
  localparam logic [STEP_W-1:0] S_MIX       = 5'd19;

  typedef struct packed {
    logic [UKP_W-1:0]         upright_kp;
    logic [UKD_W-1:0]         upright_kd;
    logic [SKP_W-1:0]         speed_kp;
    logic [TKP_W-1:0]         turn_kp;
    logic [TKD_W-1:0]         turn_kd;
    logic signed [BOFS_W-1:0] balance_offset;
    logic [FCOEF_W-1:0]       filter_coef;
    logic [MLIM_W-1:0]        motor_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ENC_W-1:0]   enc_left;
    logic signed [ENC_W-1:0]   enc_right;
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_z;
    logic                      btn_fore;
    logic                      btn_back;
    logic                      btn_left;
    logic                      btn_right;
    logic [RANGE_W-1:0]        range_cm;
    logic                      clear_integral;
  } item_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [STEP_W-1:0] step;
  } core_stat_t;

  // arithmetic shift right by 16, rounding toward zero
  function automatic logic signed [ACC_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] bias;
    bias = v[ACC_W-1] ? ACC_W'(Q16_BIAS) : '0;
    return (v + bias) >>> 16;
  endfunction

  // arithmetic shift right by 24, rounding toward zero
  function automatic logic signed [ACC_W-1:0] trunc_q24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] bias;
    bias = v[ACC_W-1] ? ACC_W'(Q24_BIAS) : '0;
    return (v + bias) >>> 24;
  endfunction

  function automatic logic signed [MOTOR_W-1:0] sat_motor(input logic signed [MIX_W-1:0] v,
                                                          input logic [MLIM_W-1:0] lim);
    logic signed [MIX_W-1:0] hi;
    logic signed [MIX_W-1:0] r;
    hi = MIX_W'(lim);
    if (v > hi) begin
      r = hi;
    end else if (v < -hi) begin
      r = -hi;
    end else begin
      r = v;
    end
    return MOTOR_W'(r);
  endfunction

endpackage

>>> src/bcp_in_if.sv
interface bcp_in_if import bcp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ENC_W-1:0]   enc_left;
  logic signed [ENC_W-1:0]   enc_right;
  logic signed [ANGLE_W-1:0] tilt_angle;
  logic signed [RATE_W-1:0]  rate_x;
  logic signed [RATE_W-1:0]  rate_z;
  logic                      btn_fore;
  logic                      btn_back;
  logic                      btn_left;
  logic                      btn_right;
  logic [RANGE_W-1:0]        range_cm;
  logic                      clear_integral;

  modport source (
    output valid, enc_left, enc_right, tilt_angle, rate_x, rate_z,
           btn_fore, btn_back, btn_left, btn_right, range_cm, clear_integral,
    input  ready
  );

  modport sink (
    input  valid, enc_left, enc_right, tilt_angle, rate_x, rate_z,
           btn_fore, btn_back, btn_left, btn_right, range_cm, clear_integral,
    output ready
  );
endinterface

>>> src/bcp_out_if.sv
interface bcp_out_if import bcp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [MOTOR_W-1:0] motor_left;
  logic signed [MOTOR_W-1:0] motor_right;

  modport source (output valid, motor_left, motor_right, input ready);
  modport sink (input valid, motor_left, motor_right, output ready);
endinterface

>>> src/balance_cascade_pid.sv
// Channel  Dir  Payload
// in_ch    in   enc_left, enc_right, tilt_angle, rate_x, rate_z, buttons, range_cm,
//               clear_integral
// out_ch   out  motor_left, motor_right
// cfg_*    in   write enable, 3-bit register index, 26-bit data
//
// A result is offered after the item has passed the 20 sequencer steps around
// one registered 27x28 multiplier. in_ch.ready is low while an item is in the sequencer,
// so the input takes no new item until the last has left it. The result sits in an output
// register; if that register is still full, the sequencer waits at its last step.
// rst_n (sync, active low) clears targets, filter and integral, restores register defaults.
`include "balance_cascade_pid_macros.svh"

module balance_cascade_pid import bcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bcp_in_if.sink                in_ch,
  bcp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  item_t      item;
  core_stat_t stat;
  logic       start;
  logic       out_free;
  logic signed [MOTOR_W-1:0] core_left;
  logic signed [MOTOR_W-1:0] core_right;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [MOTOR_W-1:0] ml_r, ml_nxt;
  logic signed [MOTOR_W-1:0] mr_r, mr_nxt;

  assign in_ch.ready = !stat.busy;
  assign start       = in_ch.valid && in_ch.ready;

  assign item.enc_left       = in_ch.enc_left;
  assign item.enc_right      = in_ch.enc_right;
  assign item.tilt_angle     = in_ch.tilt_angle;
  assign item.rate_x         = in_ch.rate_x;
  assign item.rate_z         = in_ch.rate_z;
  assign item.btn_fore       = in_ch.btn_fore;
  assign item.btn_back       = in_ch.btn_back;
  assign item.btn_left       = in_ch.btn_left;
  assign item.btn_right      = in_ch.btn_right;
  assign item.range_cm       = in_ch.range_cm;
  assign item.clear_integral = in_ch.clear_integral;

  bcp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .item        (item),
    .cfg         (cfg),
    .out_free    (out_free),
    .stat        (stat),
    .motor_left  (core_left),
    .motor_right (core_right)
  );

  // output register
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    ml_nxt        = ml_r;
    mr_nxt        = mr_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      ml_nxt        = core_left;
      mr_nxt        = core_right;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ml_r <= ml_nxt;
    mr_r <= mr_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.motor_left  = ml_r;
  assign out_ch.motor_right = mr_r;

  `BCP_ASSERT_NXT(a_start_seq, clk, rst_n, in_ch.valid && in_ch.ready, stat.busy && (stat.step == S_FE_A), "transfer did not start the sequencer")
  `BCP_ASSERT_IMP(a_step_range, clk, rst_n, stat.busy, stat.step <= S_MIX, "sequencer step out of range")
  `BCP_ASSERT_IMP(a_out_from_seq, clk, rst_n, $rose(out_ch.valid), $past(stat.done), "result appeared without a finished item")
  `BCP_ASSERT_NXT(a_done_idle, clk, rst_n, stat.done, !stat.busy, "sequencer still busy after result load")

endmodule

>>> src/bcp_cfg.sv
module bcp_cfg import bcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_UPRIGHT_KP: cfg_nxt.upright_kp     = cfg_wdata[UKP_W-1:0];
        CFG_UPRIGHT_KD: cfg_nxt.upright_kd     = cfg_wdata[UKD_W-1:0];
        CFG_SPEED_KP:   cfg_nxt.speed_kp       = cfg_wdata[SKP_W-1:0];
        CFG_TURN_KP:    cfg_nxt.turn_kp        = cfg_wdata[TKP_W-1:0];
        CFG_TURN_KD:    cfg_nxt.turn_kd        = cfg_wdata[TKD_W-1:0];
        CFG_BAL_OFFSET: cfg_nxt.balance_offset = $signed(cfg_wdata[BOFS_W-1:0]);
        CFG_FILTER:     cfg_nxt.filter_coef    = cfg_wdata[FCOEF_W-1:0];
        CFG_MOTOR_LIM:  cfg_nxt.motor_limit    = cfg_wdata[MLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upright_kp     <= RST_UPRIGHT_KP;
      cfg_r.upright_kd     <= RST_UPRIGHT_KD;
      cfg_r.speed_kp       <= RST_SPEED_KP;
      cfg_r.turn_kp        <= RST_TURN_KP;
      cfg_r.turn_kd        <= RST_TURN_KD;
      cfg_r.balance_offset <= RST_BAL_OFFSET;
      cfg_r.filter_coef    <= RST_FILTER;
      cfg_r.motor_limit    <= RST_MOTOR_LIM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/bcp_mul.sv
module bcp_mul import bcp_pkg::*; (
  input  logic                      clk,
  input  logic [MUL_A_W-1:0]        a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, a}) * b;
  end

endmodule

>>> src/bcp_core.sv
module bcp_core import bcp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  item_t                     item,
  input  cfg_t                      cfg,
  input  logic                      out_free,
  output core_stat_t                stat,
  output logic signed [MOTOR_W-1:0] motor_left,
  output logic signed [MOTOR_W-1:0] motor_right
);

  // control and loop state
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic signed [ST_W-1:0]    st_r, st_nxt;
  logic signed [TT_W-1:0]    tt_r, tt_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [FE_W-1:0]    fe_r, fe_nxt;

  // per-item working registers
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ANGLE_W-1:0] tilt_r, tilt_nxt;
  logic signed [RATE_W-1:0]  rx_r, rx_nxt;
  logic signed [RATE_W-1:0]  rz_r, rz_nxt;
  logic                      turning_r, turning_nxt;
  logic                      clr_r, clr_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [UP_W-1:0]    up_r, up_nxt;
  logic signed [TN_W-1:0]    tn_r, tn_nxt;

  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  logic [FCOEF_W-1:0] c_eff;
  logic [FCOEF_W-1:0] c_inv;
  logic [TKD_W-1:0]   kd_eff;

  logic signed [ST_W+1:0]  st_tmp;
  logic signed [TT_W+1:0]  tt_tmp;
  logic signed [ST_W-1:0]  st_new;
  logic signed [TT_W-1:0]  tt_new;
  logic signed [FE_W:0]    integ_sum;
  logic signed [INTEG_W-1:0] integ_clamp;
  logic signed [ACC_W-1:0] quot;
  logic signed [MIX_W-1:0] mix_l;
  logic signed [MIX_W-1:0] mix_r;
  logic                    done;

  assign c_eff  = (cfg.filter_coef > Q16_ONE) ? Q16_ONE : cfg.filter_coef;
  assign c_inv  = Q16_ONE - c_eff;
  assign kd_eff = turning_r ? '0 : cfg.turn_kd;

  // target ramps, evaluated on the transfer cycle
  always_comb begin
    st_tmp = (item.btn_fore || item.btn_back) ? (ST_W+2)'(st_r) : '0;
    if (item.btn_fore) begin
      st_tmp = (item.range_cm < RANGE_W'(RANGE_NEAR)) ? st_tmp - 2'sd1 : st_tmp + 2'sd1;
    end
    if (item.btn_back) begin
      st_tmp = st_tmp - 2'sd1;
    end
    if (st_tmp > SPEED_TARGET_MAX) begin
      st_new = ST_W'(SPEED_TARGET_MAX);
    end else if (st_tmp < -SPEED_TARGET_MAX) begin
      st_new = ST_W'(-SPEED_TARGET_MAX);
    end else begin
      st_new = ST_W'(st_tmp);
    end

    tt_tmp = (item.btn_left || item.btn_right) ? (TT_W+2)'(tt_r) : '0;
    if (item.btn_left) begin
      tt_tmp = tt_tmp - (TT_W+2)'(TURN_STEP);
    end
    if (item.btn_right) begin
      tt_tmp = tt_tmp + (TT_W+2)'(TURN_STEP);
    end
    if (tt_tmp > TURN_TARGET_MAX) begin
      tt_new = TT_W'(TURN_TARGET_MAX);
    end else if (tt_tmp < -TURN_TARGET_MAX) begin
      tt_new = TT_W'(-TURN_TARGET_MAX);
    end else begin
      tt_new = TT_W'(tt_tmp);
    end
  end

  always_comb begin
    integ_sum = (FE_W+1)'(integ_r) + (FE_W+1)'(fe_r);
    if (integ_sum > INTEGRAL_MAX) begin
      integ_clamp = INTEG_W'(INTEGRAL_MAX);
    end else if (integ_sum < -INTEGRAL_MAX) begin
      integ_clamp = INTEG_W'(-INTEGRAL_MAX);
    end else begin
      integ_clamp = INTEG_W'(integ_sum);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      S_FE_A: begin
        mul_a = MUL_A_W'(c_inv);
        mul_b = MUL_B_W'(err_r);
      end
      S_FE_B: begin
        mul_a = MUL_A_W'(c_eff);
        mul_b = MUL_B_W'(fe_r);
      end
      S_INTEG: begin
        mul_a = MUL_A_W'(SPEED_I_DIV);
        mul_b = MUL_B_W'(fe_r);
      end
      S_VMUL: begin
        mul_a = MUL_A_W'(cfg.speed_kp);
        mul_b = MUL_B_W'(acc_r);
      end
      S_VDIV: begin
        mul_a = INV200;
        mul_b = MUL_B_W'(acc_r);
      end
      S_UP_P: begin
        mul_a = MUL_A_W'(cfg.upright_kp);
        mul_b = MUL_B_W'(acc_r);
      end
      S_UP_D: begin
        mul_a = MUL_A_W'(cfg.upright_kd);
        mul_b = MUL_B_W'(rx_r);
      end
      S_UP_TRUNC: begin
        mul_a = MUL_A_W'(cfg.turn_kp);
        mul_b = MUL_B_W'(tt_r);
      end
      S_TN_D: begin
        mul_a = MUL_A_W'(kd_eff);
        mul_b = MUL_B_W'(rz_r);
      end
      default: ;
    endcase
  end

  bcp_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign mix_l = MIX_W'(up_r) - MIX_W'(tn_r);
  assign mix_r = MIX_W'(up_r) + MIX_W'(tn_r);
  assign done  = busy_r && (step_r == S_MIX) && out_free;

  always_comb begin
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    st_nxt      = st_r;
    tt_nxt      = tt_r;
    integ_nxt   = integ_r;
    fe_nxt      = fe_r;
    err_nxt     = err_r;
    tilt_nxt    = tilt_r;
    rx_nxt      = rx_r;
    rz_nxt      = rz_r;
    turning_nxt = turning_r;
    clr_nxt     = clr_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    up_nxt      = up_r;
    tn_nxt      = tn_r;
    quot        = ACC_W'(prod_r >>> INV200_SHIFT);

    if (start) begin
      busy_nxt    = 1'b1;
      step_nxt    = S_FE_A;
      st_nxt      = st_new;
      tt_nxt      = tt_new;
      err_nxt     = ERR_W'(item.enc_left) + ERR_W'(item.enc_right) - ERR_W'(st_new);
      tilt_nxt    = item.tilt_angle;
      rx_nxt      = item.rate_x;
      rz_nxt      = item.rate_z;
      turning_nxt = item.btn_left || item.btn_right;
      clr_nxt     = item.clear_integral;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      unique case (step_r)
        S_FE_B:     acc_nxt = ACC_W'(prod_r);
        S_FE_SUM:   acc_nxt = acc_r + ACC_W'(prod_r);
        S_FE_TRUNC: fe_nxt  = FE_W'(trunc_q16(acc_r));
        S_INTEG:    integ_nxt = clr_r ? '0 : integ_clamp;
        S_VSUM:     acc_nxt = ACC_W'(prod_r) + ACC_W'(integ_r);
        S_VQ16:     acc_nxt = trunc_q16(ACC_W'(prod_r));
        S_VABS: begin
          neg_nxt = acc_r[ACC_W-1];
          acc_nxt = acc_r[ACC_W-1] ? -acc_r : acc_r;
        end
        S_VSIGN:    acc_nxt = neg_r ? -quot : quot;
        // set point shifts by the velocity output in Q8
        S_DANG: acc_nxt = ACC_W'(tilt_r) - ((acc_r <<< 8) + ACC_W'(cfg.balance_offset));
        S_UP_D:     acc_nxt = ACC_W'(prod_r);
        S_UP_SUM:   acc_nxt = acc_r + (ACC_W'(prod_r) <<< 8);
        S_UP_TRUNC: up_nxt  = UP_W'(trunc_q24(acc_r));
        S_TN_D:     acc_nxt = ACC_W'(prod_r);
        S_TN_SUM:   acc_nxt = acc_r + ACC_W'(prod_r);
        S_TN_TRUNC: tn_nxt  = TN_W'(trunc_q16(acc_r));
        S_MIX: begin
          // hold here until the output register frees up
          step_nxt = step_r;
          if (out_free) begin
            busy_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= S_FE_A;
      st_r    <= '0;
      tt_r    <= '0;
      integ_r <= '0;
      fe_r    <= '0;
    end else begin
      busy_r  <= busy_nxt;
      step_r  <= step_nxt;
      st_r    <= st_nxt;
      tt_r    <= tt_nxt;
      integ_r <= integ_nxt;
      fe_r    <= fe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    tilt_r    <= tilt_nxt;
    rx_r      <= rx_nxt;
    rz_r      <= rz_nxt;
    turning_r <= turning_nxt;
    clr_r     <= clr_nxt;
    acc_r     <= acc_nxt;
    neg_r     <= neg_nxt;
    up_r      <= up_nxt;
    tn_r      <= tn_nxt;
  end

  assign stat.busy   = busy_r;
  assign stat.done   = done;
  assign stat.step   = step_r;
  assign motor_left  = sat_motor(mix_l, cfg.motor_limit);
  assign motor_right = sat_motor(mix_r, cfg.motor_limit);

endmodule
